// File: rtl/rrcs_pkg.sv
// ----------------------------------------------------------------------------
// RTCP report rewrite checksum - shared package
// Word types, register indexes, mode codes and the folding checksum add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrcs_pkg;

	localparam int unsigned MAX_PACKET_BYTES = 65535;

	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] RTCP_TYPE_RR = 8'd201;

	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_JITTER   = 2'd1;
	localparam logic [1:0] CFG_FRACTION = 2'd2;

	localparam logic [1:0] MODE_ACCEPT        = 2'd0;
	localparam logic [1:0] MODE_DROP_INJECT   = 2'd1;
	localparam logic [1:0] MODE_ACCEPT_INJECT = 2'd2;

	localparam logic [1:0]  MODE_RESET     = MODE_DROP_INJECT;
	localparam logic [31:0] JITTER_RESET   = 32'd100;
	localparam logic [7:0]  FRACTION_RESET = 8'd10;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       eop;
	} rrcs_in_t;

	typedef struct packed {
		logic        is_report;
		logic        drop_packet;
		logic        inject_copy;
		logic [15:0] ip_checksum;
		logic [15:0] udp_checksum;
		logic [6:0]  report_offset;
	} rrcs_out_t;

	// per-packet state captured at the last byte
	typedef struct packed {
		logic [15:0] pos;
		logic [5:0]  header_bytes;
		logic [16:0] ip_sum;
		logic [16:0] udp_sum;
		logic [15:0] udp_len;
		logic        ipv4_udp_seen;
		logic        rtcp_type_seen;
	} rrcs_snap_t;

	// ones' complement add with a single end-around fold
	function automatic logic [16:0] fold_add(input logic [16:0] s, input logic [15:0] v);
		logic [16:0] t;
		t = s + {1'b0, v};
		return {1'b0, t[15:0]} + {16'd0, t[16]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/rrcs_accum.sv
// ----------------------------------------------------------------------------
// RTCP report rewrite checksum - byte accumulator
// Input register, per-byte parsing and running checksums; hands the packet
// state on at the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrcs_accum
	import rrcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire rrcs_in_t    in_word,
	input  wire logic [31:0] jitter_value,
	input  wire logic [7:0]  fraction_value,
	output logic             snap_valid,
	input  wire logic        snap_stall,
	output rrcs_snap_t       snap
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [15:0] pos_q;
	logic [5:0]  hb_q;
	logic [16:0] ip_q;
	logic [16:0] udp_q;
	logic [15:0] len_q;
	logic        ipv4_q;
	logic        rtcp_q;

	logic        snap_valid_s2;
	rrcs_snap_t  snap_s2;

	logic        snap_free;
	logic        consume;
	logic        accept;

	logic [5:0]  hb_eff;
	logic [15:0] lane;
	logic [15:0] off;
	logic [7:0]  v;
	logic        take;
	logic        pseudo;
	logic        beyond_hdr;
	rrcs_snap_t  nxt;

	assign snap_free = !snap_valid_s2 || !snap_stall;
	assign consume   = valid_s1 && (!last_s1 || snap_free);
	assign in_stall  = valid_s1 && !consume;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		hb_eff     = (pos_q == 16'd0) ? {byte_s1[3:0], 2'b00} : hb_q;
		beyond_hdr = pos_q >= {10'd0, hb_eff};
		off        = pos_q - {10'd0, hb_eff};

		nxt.pos          = pos_q;
		nxt.header_bytes = hb_eff;
		nxt.ip_sum       = ip_q;
		nxt.udp_sum      = udp_q;
		nxt.udp_len      = len_q;
		nxt.ipv4_udp_seen  = ipv4_q;
		nxt.rtcp_type_seen = rtcp_q;

		if (pos_q == 16'd0)
			nxt.ipv4_udp_seen = (byte_s1[7:4] == 4'd4) && (byte_s1[3:0] >= 4'd5);
		if (pos_q == 16'd9 && byte_s1 != PROTO_UDP)
			nxt.ipv4_udp_seen = 1'b0;

		lane = pos_q[0] ? {8'd0, byte_s1} : {byte_s1, 8'd0};
		if (pos_q < {10'd0, hb_eff} && pos_q != 16'd10 && pos_q != 16'd11)
			nxt.ip_sum = fold_add(ip_q, lane);

		if (beyond_hdr) begin
			if (off == 16'd4) nxt.udp_len = {byte_s1, len_q[7:0]};
			if (off == 16'd5) nxt.udp_len = {len_q[15:8], byte_s1};
			if (off == 16'd8) nxt.rtcp_type_seen = (byte_s1[7:6] == 2'd2);
			if (off == 16'd9 && byte_s1 != RTCP_TYPE_RR) nxt.rtcp_type_seen = 1'b0;
		end

		// report fields: fraction lost at offset 20, jitter at 28..31
		v = byte_s1;
		case (off)
			16'd20:  v = fraction_value;
			16'd28:  v = jitter_value[31:24];
			16'd29:  v = jitter_value[23:16];
			16'd30:  v = jitter_value[15:8];
			16'd31:  v = jitter_value[7:0];
			default: v = byte_s1;
		endcase
		take   = beyond_hdr && ((off < 16'd6) || (off >= 16'd8 && off < nxt.udp_len));
		pseudo = (pos_q >= 16'd12) && (pos_q <= 16'd19);
		if (pseudo)
			nxt.udp_sum = fold_add(udp_q, lane);
		else if (take)
			nxt.udp_sum = fold_add(udp_q, pos_q[0] ? {8'd0, v} : {v, 8'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_word.packet_byte;
			last_s1 <= in_word.eop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hb_q   <= '0;
			ip_q   <= '0;
			udp_q  <= '0;
			len_q  <= '0;
			ipv4_q <= 1'b0;
			rtcp_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				pos_q  <= '0;
				hb_q   <= '0;
				ip_q   <= '0;
				udp_q  <= '0;
				len_q  <= '0;
				ipv4_q <= 1'b0;
				rtcp_q <= 1'b0;
			end else begin
				if (pos_q < 16'(MAX_PACKET_BYTES)) pos_q <= pos_q + 16'd1;
				hb_q   <= nxt.header_bytes;
				ip_q   <= nxt.ip_sum;
				udp_q  <= nxt.udp_sum;
				len_q  <= nxt.udp_len;
				ipv4_q <= nxt.ipv4_udp_seen;
				rtcp_q <= nxt.rtcp_type_seen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (snap_free) begin
			snap_valid_s2 <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_free && consume && last_s1) snap_s2 <= nxt;
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

`default_nettype wire

// File: rtl/rrcs_finish.sv
// ----------------------------------------------------------------------------
// RTCP report rewrite checksum - verdict and result register
// Report test, final checksum folds and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrcs_finish
	import rrcs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       snap_valid,
	output logic            snap_stall,
	input  wire rrcs_snap_t snap,
	input  wire logic [1:0] mode,
	output logic            out_valid,
	input  wire logic       out_stall,
	output rrcs_out_t       out_word
);

	logic        out_valid_q;
	rrcs_out_t   out_word_q;
	rrcs_out_t   res;

	logic        report;
	logic [16:0] span;
	logic [16:0] need;
	logic [16:0] s_proto;
	logic [16:0] s_len;
	logic [15:0] udpck;
	logic        load;

	assign snap_stall = out_valid_q && out_stall;
	assign load       = snap_valid && !snap_stall;

	always_comb begin
		span    = {1'b0, snap.pos} + 17'd1;
		need    = {11'd0, snap.header_bytes} + {1'b0, snap.udp_len};
		report  = snap.ipv4_udp_seen && snap.rtcp_type_seen && (snap.udp_len >= 16'd16)
		          && (snap.pos < 16'(MAX_PACKET_BYTES)) && (span >= need);
		s_proto = fold_add(snap.udp_sum, {8'd0, PROTO_UDP});
		s_len   = fold_add(s_proto, snap.udp_len);
		udpck   = ~s_len[15:0];
		if (udpck == 16'd0) udpck = 16'hFFFF;

		res = '0;
		if (report) begin
			res.is_report     = 1'b1;
			res.ip_checksum   = ~snap.ip_sum[15:0];
			res.udp_checksum  = udpck;
			res.report_offset = {1'b0, snap.header_bytes} + 7'd8;
			case (mode)
				MODE_DROP_INJECT: begin
					res.drop_packet = 1'b1;
					res.inject_copy = 1'b1;
				end
				MODE_ACCEPT_INJECT: begin
					res.inject_copy = 1'b1;
				end
				default: begin
					res.drop_packet = 1'b0;
					res.inject_copy = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_word_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

// File: rtl/rtcp_report_rewrite_checksum_unit.sv
// ----------------------------------------------------------------------------
// RTCP report rewrite checksum unit - top level
// Classifies IPv4 packets as RTCP receiver reports and yields the IP header
// checksum and the UDP checksum of a copy with rewritten jitter and fraction.
// ----------------------------------------------------------------------------
// One packet byte is taken per clock. Each byte passes an input register, is
// folded into the running sums as it leaves that register, and the byte marked
// last hands the packet state through a snapshot register to a verdict stage,
// whose result word is registered in the output register. Throughput is one
// byte per cycle, including single-byte packets back to back; the input stalls
// only while a last byte waits behind a held result word. Configuration writes
// are always ready and should be made between packets.
`timescale 1ns / 1ps
`default_nettype none

module rtcp_report_rewrite_checksum_unit
	import rrcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire rrcs_in_t    in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output rrcs_out_t        out_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [1:0]  mode_q;
	logic [31:0] jitter_q;
	logic [7:0]  fraction_q;

	logic        snap_valid;
	logic        snap_stall;
	rrcs_snap_t  snap;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESET;
			jitter_q   <= JITTER_RESET;
			fraction_q <= FRACTION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:     mode_q     <= cfg_data[1:0];
				CFG_JITTER:   jitter_q   <= cfg_data;
				CFG_FRACTION: fraction_q <= cfg_data[7:0];
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	rrcs_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_word        (in_word),
		.jitter_value   (jitter_q),
		.fraction_value (fraction_q),
		.snap_valid     (snap_valid),
		.snap_stall     (snap_stall),
		.snap           (snap)
	);

	rrcs_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_stall (snap_stall),
		.snap       (snap),
		.mode       (mode_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

endmodule

`default_nettype wire

// File: rtl/rrcs_checker.sv
// ----------------------------------------------------------------------------
// RTCP report rewrite checksum - port checker
// Concurrent checks on the result word seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrcs_checker
	import rrcs_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire rrcs_out_t out_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.is_report |-> !out_word.drop_packet && !out_word.inject_copy
		&& out_word.ip_checksum == 16'd0 && out_word.udp_checksum == 16'd0
		&& out_word.report_offset == 7'd0)
		else $error("non-report word carries data");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.is_report |-> out_word.report_offset >= 7'd28
		&& out_word.report_offset <= 7'd68 && out_word.report_offset[1:0] == 2'd0)
		else $error("report offset out of range");

	a_udpck: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.is_report |-> out_word.udp_checksum != 16'd0)
		else $error("zero UDP checksum sent");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.drop_packet |-> out_word.inject_copy && out_word.is_report)
		else $error("drop without injection");

endmodule

bind rtcp_report_rewrite_checksum_unit rrcs_checker u_rrcs_checker (.*);

`default_nettype wire
